[src/uapq_pkg.sv]
package uapq_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		KIND_PUSH   = 2'd0,
		KIND_POP    = 2'd1,
		KIND_DELETE = 2'd2,
		KIND_QUERY  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [15:0] job;
		logic [15:0] prio;
	} entry_t;

	// Best entry found among a cell and everything above it.
	typedef struct packed {
		logic             valid;
		entry_t           ent;
		logic [IDX_W-1:0] idx;
	} best_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	// True when a ranks ahead of b; on a full tie a wins only if tie_wins is set.
	function automatic logic outranks(entry_t a, entry_t b, logic tie_wins);
		logic prio_gt;
		logic prio_eq;
		logic job_gt;
		logic job_eq;
		prio_gt = $signed(a.prio) > $signed(b.prio);
		prio_eq = a.prio == b.prio;
		job_gt = a.job > b.job;
		job_eq = a.job == b.job;
		return prio_gt || (prio_eq && (job_gt || (job_eq && tie_wins)));
	endfunction

endpackage

[src/unsorted_array_priority_queue.sv]
// Priority queue of up to CAPACITY jobs kept in arrival order in a row of cells.
// Input channel (in_valid/in_ready): kind, job_number, priority_req. Push appends,
// pop takes the highest priority (larger job number on equal priority), delete
// removes the first stored job with a matching number, query only reports.
// Output channel (out_valid/out_ready): one result per input transfer with the
// status, the removed job, the front job and priority, and the job count.
// After its transfer an item passes through S_FINISH, which loads the result into
// the output register once that register is free; the next transfer is taken
// back in S_IDLE. When an item removes the current front job, it first waits in
// S_SCAN while the best-of-suffix chain through the cells settles, and the new
// front is taken from the chain's head. Items are worked one at a time.
// When the receiver stalls, the result holds in the output register; one more
// item may be taken and finished, then it waits until the register is free.
// Reset empties the queue and drops out_valid; stored entries are
// not cleared, since only slots below the count are ever read.
module unsorted_array_priority_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [15:0]        job_number,
	input  logic signed [15:0] priority_req,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic               removed_valid,
	output logic [15:0]        removed_job,
	output logic               front_valid,
	output logic [15:0]        front_job,
	output logic signed [15:0] front_priority,
	output logic [4:0]         job_count
);
	import uapq_pkg::*;

	typedef struct packed {
		entry_t           ent;
		logic [IDX_W-1:0] idx;
	} front_t;

	state_t state_q, state_d;

	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] scan_q;
	front_t           front_q, front_d;

	status_t     res_status_q;
	logic        res_rm_valid_q;
	logic [15:0] res_rm_job_q;

	logic        out_valid_q;
	status_t     out_status_q;
	logic        out_rm_valid_q;
	logic [15:0] out_rm_job_q;
	logic        out_front_valid_q;
	logic [15:0] out_front_job_q;
	logic [15:0] out_front_prio_q;
	logic [4:0]  out_count_q;

	entry_t    cell_entry [CAPACITY];
	best_t     cell_best  [CAPACITY];
	entry_t    cell_next  [CAPACITY];
	best_t     cell_nbest [CAPACITY];
	cell_ctl_t cell_ctl   [CAPACITY];
	logic      cell_live  [CAPACITY];

	entry_t           new_entry;
	logic             accept;
	logic             found;
	logic [IDX_W-1:0] match_idx;
	status_t          op_status;
	logic             op_rm_valid;
	logic [15:0]      op_rm_job;
	logic [IDX_W-1:0] rm_idx;
	logic             do_rm;
	logic             do_push;
	logic             rescan;
	logic             load_out;

	assign new_entry = '{job: job_number, prio: priority_req};
	assign accept = in_valid && in_ready;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			if (g == CAPACITY - 1) begin : g_last
				assign cell_next[g] = '0;
				assign cell_nbest[g] = '0;
			end else begin : g_mid
				assign cell_next[g] = cell_entry[g + 1];
				assign cell_nbest[g] = cell_best[g + 1];
			end

			assign cell_live[g] = CNT_W'(g) < count_q;
			assign cell_ctl[g].load = accept && do_push && (count_q == CNT_W'(g));
			assign cell_ctl[g].shift = accept && do_rm && (IDX_W'(g) >= rm_idx);

			uapq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (cell_ctl[g]),
				.new_entry  (new_entry),
				.next_entry (cell_next[g]),
				.next_best  (cell_nbest[g]),
				.live       (cell_live[g]),
				.cell_idx   (IDX_W'(g)),
				.entry      (cell_entry[g]),
				.best       (cell_best[g])
			);
		end
	endgenerate

	// First stored job with the requested number.
	always_comb begin
		found = 1'b0;
		match_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (!found && cell_live[i] && (cell_entry[i].job == job_number)) begin
				found = 1'b1;
				match_idx = IDX_W'(i);
			end
		end
	end

	// Effect of the presented item on count, front and the cells.
	always_comb begin
		op_status = STAT_OK;
		op_rm_valid = 1'b0;
		op_rm_job = '0;
		rm_idx = '0;
		do_rm = 1'b0;
		do_push = 1'b0;
		rescan = 1'b0;
		front_d = front_q;
		count_d = count_q;
		case (kind_t'(kind))
			KIND_PUSH: begin
				if (count_q == CNT_W'(CAPACITY)) begin
					op_status = STAT_FULL;
				end else begin
					do_push = 1'b1;
					count_d = CNT_W'(count_q + 1'b1);
					// A later arrival takes the front only when strictly ahead.
					if (count_q == '0 || outranks(new_entry, front_q.ent, 1'b0)) begin
						front_d = '{ent: new_entry, idx: IDX_W'(count_q)};
					end
				end
			end
			KIND_POP: begin
				if (count_q == '0) begin
					op_status = STAT_EMPTY;
				end else begin
					op_rm_valid = 1'b1;
					op_rm_job = front_q.ent.job;
					rm_idx = front_q.idx;
					do_rm = 1'b1;
					rescan = 1'b1;
					count_d = CNT_W'(count_q - 1'b1);
				end
			end
			KIND_DELETE: begin
				if (count_q == '0) begin
					op_status = STAT_EMPTY;
				end else if (!found) begin
					op_status = STAT_NOT_FOUND;
				end else begin
					op_rm_valid = 1'b1;
					op_rm_job = job_number;
					rm_idx = match_idx;
					do_rm = 1'b1;
					count_d = CNT_W'(count_q - 1'b1);
					if (match_idx == front_q.idx) begin
						rescan = 1'b1;
					end else if (match_idx < front_q.idx) begin
						front_d.idx = IDX_W'(front_q.idx - 1'b1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = rescan ? S_SCAN : S_FINISH;
				end
			end
			S_SCAN: begin
				if (scan_q == '0) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			front_q <= front_d;
			scan_q <= CNT_W'(CAPACITY);
			res_status_q <= op_status;
			res_rm_valid_q <= op_rm_valid;
			res_rm_job_q <= op_rm_job;
		end else if (state_q == S_SCAN) begin
			if (scan_q == '0) begin
				// The suffix chain has settled; its head holds the new front.
				front_q <= '{ent: cell_best[0].ent, idx: cell_best[0].idx};
			end else begin
				scan_q <= CNT_W'(scan_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= res_status_q;
			out_rm_valid_q <= res_rm_valid_q;
			out_rm_job_q <= res_rm_job_q;
			out_front_valid_q <= count_q != '0;
			out_front_job_q <= (count_q != '0) ? front_q.ent.job : 16'd0;
			out_front_prio_q <= (count_q != '0) ? front_q.ent.prio : 16'd0;
			out_count_q <= 5'(count_q);
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign removed_valid = out_rm_valid_q;
	assign removed_job = out_rm_job_q;
	assign front_valid = out_front_valid_q;
	assign front_job = out_front_job_q;
	assign front_priority = $signed(out_front_prio_q);
	assign job_count = out_count_q;

endmodule

[src/uapq_cell.sv]
module uapq_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  uapq_pkg::cell_ctl_t          ctl,
	input  uapq_pkg::entry_t             new_entry,
	input  uapq_pkg::entry_t             next_entry,
	input  uapq_pkg::best_t              next_best,
	input  logic                         live,
	input  logic [uapq_pkg::IDX_W-1:0]   cell_idx,
	output uapq_pkg::entry_t             entry,
	output uapq_pkg::best_t              best
);
	import uapq_pkg::*;

	entry_t entry_q;
	best_t  best_q;
	best_t  best_d;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= new_entry;
		end else if (ctl.shift) begin
			entry_q <= next_entry;
		end
	end

	// The earlier slot wins a full tie, so this cell beats an equal entry above it.
	always_comb begin
		if (live && (!next_best.valid || outranks(entry_q, next_best.ent, 1'b1))) begin
			best_d = '{valid: 1'b1, ent: entry_q, idx: cell_idx};
		end else begin
			best_d = next_best;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else begin
			best_q <= best_d;
		end
	end

	assign entry = entry_q;
	assign best = best_q;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
	import uapq_pkg::*;

	typedef struct packed {
		status_t     status;
		logic        removed_valid;
		logic [15:0] removed_job;
		logic        front_valid;
		logic [15:0] front_job;
		logic [15:0] front_priority;
		logic [4:0]  job_count;
	} queue_reply_t;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         kind;
	logic [15:0]        job_number;
	logic signed [15:0] priority_req;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic               removed_valid;
	logic [15:0]        removed_job;
	logic               front_valid;
	logic [15:0]        front_job;
	logic signed [15:0] front_priority;
	logic [4:0]         job_count;

	// Shadow of the job table, advanced at each input transfer.
	logic [15:0]        held_job [CAPACITY];
	logic signed [15:0] held_prio [CAPACITY];
	int                 held_count = 0;

	queue_reply_t pending_replies [$];
	int           errors = 0;
	int           burst_left = 0;
	int           mode_left = 0;
	rx_mode_t     rx_mode = RX_OPEN;

	unsorted_array_priority_queue u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.job_number    (job_number),
		.priority_req  (priority_req),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.removed_valid (removed_valid),
		.removed_job   (removed_job),
		.front_valid   (front_valid),
		.front_job     (front_job),
		.front_priority(front_priority),
		.job_count     (job_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Slot that a pop would take: highest priority, then larger job number,
	// then the earliest stored entry.
	function automatic int front_slot();
		int top;
		top = 0;
		for (int i = 1; i < held_count; i++) begin
			if (held_prio[i] > held_prio[top] ||
			    (held_prio[i] == held_prio[top] && held_job[i] > held_job[top]))
				top = i;
		end
		return top;
	endfunction

	function automatic void take_slot(int slot);
		for (int i = slot; i + 1 < held_count; i++) begin
			held_job[i] = held_job[i + 1];
			held_prio[i] = held_prio[i + 1];
		end
		held_count--;
	endfunction

	function automatic queue_reply_t apply_request(kind_t k, logic [15:0] jn,
	                                               logic signed [15:0] pr);
		queue_reply_t r;
		int slot;
		r = '0;
		r.status = STAT_OK;
		case (k)
		KIND_PUSH: begin
			if (held_count >= CAPACITY) begin
				r.status = STAT_FULL;
			end else begin
				held_job[held_count] = jn;
				held_prio[held_count] = pr;
				held_count++;
			end
		end
		KIND_POP: begin
			if (held_count == 0) begin
				r.status = STAT_EMPTY;
			end else begin
				slot = front_slot();
				r.removed_valid = 1'b1;
				r.removed_job = held_job[slot];
				take_slot(slot);
			end
		end
		KIND_DELETE: begin
			if (held_count == 0) begin
				r.status = STAT_EMPTY;
			end else begin
				// Walk down so that the first match is the one that sticks.
				slot = -1;
				for (int i = held_count - 1; i >= 0; i--) begin
					if (held_job[i] == jn)
						slot = i;
				end
				if (slot >= 0) begin
					r.removed_valid = 1'b1;
					r.removed_job = jn;
					take_slot(slot);
				end else begin
					r.status = STAT_NOT_FOUND;
				end
			end
		end
		default: ;
		endcase
		if (held_count > 0) begin
			slot = front_slot();
			r.front_valid = 1'b1;
			r.front_job = held_job[slot];
			r.front_priority = held_prio[slot];
		end
		r.job_count = 5'(held_count);
		return r;
	endfunction

	function automatic logic [15:0] random_job();
		case ($urandom_range(0, 9))
		0: return 16'h0000;
		1: return 16'hFFFF;
		2, 3, 4, 5: return 16'($urandom_range(0, 7));
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [15:0] random_priority();
		case ($urandom_range(0, 9))
		0: return 16'sh8000;
		1: return 16'sh7FFF;
		2, 3, 4: return 16'($urandom_range(0, 4) - 2);
		default: return 16'($urandom);
		endcase
	endfunction

	// Sender works in bursts; valid drops only when a gap follows.
	task automatic send_item(kind_t k, logic [15:0] jn, logic signed [15:0] pr);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		kind <= k;
		job_number <= jn;
		priority_req <= pr;
		do @(posedge clk); while (!in_ready);
		pending_replies.push_back(apply_request(k, jn, pr));
		burst_left--;
		if (burst_left == 0)
			in_valid <= 1'b0;
	endtask

	task automatic wait_for_drain();
		if (burst_left != 0) begin
			in_valid <= 1'b0;
			burst_left = 0;
		end
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_table();
		send_item(KIND_POP, 16'h0000, 16'sh0000);
		send_item(KIND_DELETE, 16'hFFFF, 16'sh0000);
		send_item(KIND_QUERY, 16'h1234, -16'sd5);
	endtask

	// Ties on priority, full ties, duplicate numbers and extremes, then one
	// push past capacity.
	task automatic test_fill_to_full();
		send_item(KIND_PUSH, 16'h0000, 16'sh8000);
		send_item(KIND_PUSH, 16'hFFFF, 16'sh7FFF);
		send_item(KIND_PUSH, 16'h0005, 16'sd100);
		send_item(KIND_PUSH, 16'h0007, 16'sd100);
		send_item(KIND_PUSH, 16'h0005, 16'sd100);
		send_item(KIND_PUSH, 16'hFFFF, 16'sh7FFF);
		while (held_count < CAPACITY)
			send_item(KIND_PUSH, random_job(), random_priority());
		send_item(KIND_PUSH, 16'hBEEF, 16'sh7FFF);
	endtask

	task automatic test_remove_paths();
		logic [15:0] absent;
		logic        clash;
		send_item(KIND_POP, 16'h0000, 16'sh0000);
		send_item(KIND_DELETE, 16'h0005, 16'sh0000);
		do begin
			absent = 16'($urandom);
			clash = 1'b0;
			for (int i = 0; i < held_count; i++)
				clash |= held_job[i] == absent;
		end while (clash);
		send_item(KIND_DELETE, absent, 16'sh0000);
		send_item(KIND_QUERY, 16'hFFFF, 16'sh7FFF);
	endtask

	// Phases lean toward filling, toward draining, or stay balanced, so the
	// count sweeps between empty and full.
	task automatic test_random_traffic(int n_items);
		int          phase_left;
		int          push_pct;
		int          pop_pct;
		int          del_pct;
		int          roll;
		kind_t       k;
		logic [15:0] jn;
		phase_left = 0;
		push_pct = 40;
		pop_pct = 30;
		del_pct = 25;
		for (int n = 0; n < n_items; n++) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 120);
				case ($urandom_range(0, 2))
				0: begin
					push_pct = 70; pop_pct = 15; del_pct = 10;
				end
				1: begin
					push_pct = 20; pop_pct = 45; del_pct = 30;
				end
				default: begin
					push_pct = 40; pop_pct = 30; del_pct = 25;
				end
				endcase
			end
			phase_left--;
			roll = $urandom_range(0, 99);
			if (roll < push_pct)
				k = KIND_PUSH;
			else if (roll < push_pct + pop_pct)
				k = KIND_POP;
			else if (roll < push_pct + pop_pct + del_pct)
				k = KIND_DELETE;
			else
				k = KIND_QUERY;
			jn = random_job();
			if (k == KIND_DELETE && held_count > 0 && $urandom_range(0, 9) < 7)
				jn = held_job[$urandom_range(0, held_count - 1)];
			send_item(k, jn, random_priority());
		end
	endtask

	// Receiver stalls on its own schedule of modes.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			mode_left = $urandom_range(50, 300);
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		end
		mode_left--;
		case (rx_mode)
		RX_OPEN: out_ready <= 1'b1;
		RX_COIN: out_ready <= 1'($urandom_range(0, 1));
		RX_SPARSE: out_ready <= $urandom_range(0, 7) == 0;
		default: out_ready <= mode_left[2];
		endcase
	end

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : reply_check
		queue_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: result transfer with no request outstanding", $time);
				errors++;
			end else begin
				want = pending_replies.pop_front();
				check_field("status", 16'(want.status), 16'(status));
				check_field("removed_valid", 16'(want.removed_valid), 16'(removed_valid));
				check_field("removed_job", want.removed_job, removed_job);
				check_field("front_valid", 16'(want.front_valid), 16'(front_valid));
				check_field("front_job", want.front_job, front_job);
				check_field("front_priority", want.front_priority, front_priority);
				check_field("job_count", 16'(want.job_count), 16'(job_count));
			end
		end
	end

	initial begin
		in_valid = 1'b0;
		kind = KIND_QUERY;
		job_number = 16'h0000;
		priority_req = 16'sh0000;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_fill_to_full();
		test_remove_paths();
		wait_for_drain();
		test_random_traffic(800);
		wait_for_drain();
		test_random_traffic(800);
		wait_for_drain();

		// Every result has been taken here, so no removal of the front job is still settling.
		repeat (CAPACITY + 10) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
src/uapq_pkg.sv
src/uapq_cell.sv
src/unsorted_array_priority_queue.sv
tb/tb.sv
